### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the variable-length integer codec.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/ucodec_pkg.sv
// ----------------------------------------------------------------------------
// ucodec_pkg
// Shared constants, codes, control struct and helpers of the integer codec.
// ----------------------------------------------------------------------------
`default_nettype none

package ucodec_pkg;

	localparam int MAX_BYTES   = 6;
	localparam int CHUNK_W     = 6;
	localparam int WORK_W      = CHUNK_W * MAX_BYTES;
	localparam int VAL_W       = 5 * MAX_BYTES + 1;
	localparam int VALUE_IN_W  = 42;
	localparam int VALUE_OUT_W = 31;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 3;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BYTE  = 2'd0;
	localparam kind_t KIND_VALUE = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	typedef logic [1:0] err_t;
	localparam err_t ERR_NONE   = 2'd0;
	localparam err_t ERR_RANGE  = 2'd1;
	localparam err_t ERR_HEADER = 2'd2;
	localparam err_t ERR_CONT   = 2'd3;

	typedef struct packed {
		logic enc_load;
		logic enc_step;
		logic dec_load;
		logic dec_step;
		logic dec_clear;
	} ucodec_ctl_t;

	// number of bytes for a value of at least 128
	function automatic logic [LEN_W-1:0] enc_len(input logic [VAL_W-1:0] v);
		logic [LEN_W-1:0] k;
		k = LEN_W'(MAX_BYTES);
		for (int i = MAX_BYTES - 1; i >= 2; i--) begin
			if ((v >> (5 * i + 1)) == '0)
				k = LEN_W'(i);
		end
		return k;
	endfunction

	function automatic logic [3:0] lead_ones(input logic [BYTE_W-1:0] b);
		logic [3:0] n;
		logic       stop;
		n    = 4'd0;
		stop = 1'b0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!stop && b[i])
				n = n + 4'd1;
			else
				stop = 1'b1;
		end
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] hdr_mask(input logic [LEN_W-1:0] k);
		logic [BYTE_W-1:0] ones;
		ones = '1;
		return BYTE_W'(ones << (BYTE_W - int'(k)));
	endfunction

	// left-align a value so that its first chunk sits at the top of the word
	function automatic logic [WORK_W-1:0] align(input logic [VAL_W-1:0] v,
			input logic [LEN_W-1:0] k);
		logic [WORK_W-1:0] w;
		w = WORK_W'(v);
		return w << (CHUNK_W * (MAX_BYTES - int'(k)));
	endfunction

endpackage

`default_nettype wire

### rtl/utf8_style_integer_codec_unit.sv
// ----------------------------------------------------------------------------
// utf8_style_integer_codec_unit
// Encoder and byte-wise decoder for integers in the six-byte UTF-8 layout.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): operation selects encode of value or
// decode of byte_in. Output channel (out_valid/out_stall): one transaction
// per result, with kind, payload fields and last on the final result of an
// input transaction.
// The block takes one input transaction at a time; in_stall is high while it
// works. A decode byte is accepted, then takes one sequencer step, and
// gives at most one result. An encode of a k-byte code (k = 1..6) is
// accepted, then the sequencer emits one byte per cycle by stepping the work
// word through the shared six-bit shift unit, header first. A range error
// gives a single result.
// Each sequencer step waits until the output register is free, so a stall
// on the output simply holds the step and the block stays busy.
// Reset clears the decoder to waiting for a header, drops out_valid and
// returns the sequencer to idle. Encoding never disturbs a partial decode.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module utf8_style_integer_codec_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                operation,
	input  wire logic [ucodec_pkg::VALUE_IN_W-1:0]   value,
	input  wire logic [ucodec_pkg::BYTE_W-1:0]       byte_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [1:0]                          kind,
	output logic      [ucodec_pkg::BYTE_W-1:0]       byte_out,
	output logic      [ucodec_pkg::VALUE_OUT_W-1:0]  value_out,
	output logic      [ucodec_pkg::LEN_W-1:0]        byte_count,
	output logic      [1:0]                          error_code,
	output logic      [2:0]                          error_position,
	output logic                                     last
);
	import ucodec_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t               state_q;
	logic                 op_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 enc_err_q;
	logic [LEN_W-1:0]     enc_k_q;
	logic [LEN_W-1:0]     idx_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     seq_q;

	logic                 out_valid_q;
	kind_t                kind_q;
	logic [BYTE_W-1:0]    byte_out_q;
	logic [VALUE_OUT_W-1:0] value_out_q;
	logic [LEN_W-1:0]     byte_count_q;
	err_t                 error_code_q;
	logic [2:0]           error_pos_q;
	logic                 last_q;

	ucodec_ctl_t          ctl;
	logic [CHUNK_W-1:0]   chunk;
	logic [VAL_W-1:0]     acc_next;

	logic                 accept;
	logic                 out_free;
	logic                 one_byte;
	logic                 too_large;
	logic [LEN_W-1:0]     enc_k_new;
	logic [3:0]           n_ones;

	logic                 res_valid;
	kind_t                res_kind;
	logic [BYTE_W-1:0]    res_byte;
	logic [VALUE_OUT_W-1:0] res_value;
	logic [LEN_W-1:0]     res_count;
	err_t                 res_err;
	logic [2:0]           res_pos;
	logic                 done;
	logic [LEN_W-1:0]     rem_n;
	logic [LEN_W-1:0]     seq_n;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign one_byte  = (value[VALUE_IN_W-1:7] == '0);
	assign too_large = |value[VALUE_IN_W-1:VAL_W];
	assign enc_k_new = one_byte ? LEN_W'(1) : enc_len(value[VAL_W-1:0]);
	assign n_ones    = lead_ones(byte_q);

	ucodec_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.value_in (value[VAL_W-1:0]),
		.enc_k    (enc_k_new),
		.byte_in  (byte_q),
		.chunk    (chunk),
		.acc_next (acc_next)
	);

	always_comb begin
		ctl          = '0;
		ctl.enc_load = accept && !operation;
		res_valid    = 1'b0;
		res_kind     = KIND_BYTE;
		res_byte     = '0;
		res_value    = '0;
		res_count    = '0;
		res_err      = ERR_NONE;
		res_pos      = '0;
		done         = 1'b0;
		rem_n        = rem_q;
		seq_n        = seq_q;
		if (state_q == ST_RUN && out_free) begin
			if (!op_q) begin
				res_valid = 1'b1;
				res_count = enc_k_q;
				if (enc_err_q) begin
					res_kind  = KIND_ERROR;
					res_err   = ERR_RANGE;
					res_count = '0;
					done      = 1'b1;
				end else if (enc_k_q == LEN_W'(1)) begin
					res_byte = {1'b0, byte_q[6:0]};
					done     = 1'b1;
				end else begin
					ctl.enc_step = 1'b1;
					if (idx_q == '0)
						res_byte = hdr_mask(enc_k_q) | BYTE_W'(chunk);
					else
						res_byte = {2'b10, chunk};
					done = (idx_q == enc_k_q - LEN_W'(1));
				end
			end else begin
				done = 1'b1;
				if (rem_q == '0) begin
					if (!byte_q[7]) begin
						res_valid = 1'b1;
						res_kind  = KIND_VALUE;
						res_value = VALUE_OUT_W'(byte_q);
						res_count = LEN_W'(1);
					end else if (n_ones >= 4'd7 || n_ones > 4'(MAX_BYTES)) begin
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_HEADER;
					end else if (n_ones == 4'd1) begin
						// lone continuation byte taken as a one-byte value
						res_valid = 1'b1;
						res_kind  = KIND_VALUE;
						res_value = VALUE_OUT_W'(byte_q[6:0]);
						res_count = LEN_W'(1);
					end else begin
						ctl.dec_load = 1'b1;
						seq_n        = LEN_W'(n_ones);
						rem_n        = LEN_W'(n_ones - 4'd1);
					end
				end else if (byte_q[7:6] != 2'b10) begin
					res_valid     = 1'b1;
					res_kind      = KIND_ERROR;
					res_err       = ERR_CONT;
					res_pos       = seq_q - rem_q;
					ctl.dec_clear = 1'b1;
					rem_n         = '0;
					seq_n         = '0;
				end else begin
					ctl.dec_step = 1'b1;
					rem_n        = rem_q - LEN_W'(1);
					if (rem_q == LEN_W'(1)) begin
						res_valid     = 1'b1;
						res_kind      = KIND_VALUE;
						res_value     = VALUE_OUT_W'(acc_next);
						res_count     = seq_q;
						ctl.dec_clear = 1'b1;
						seq_n         = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= 1'b0;
			enc_err_q   <= 1'b0;
			enc_k_q     <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rem_q <= rem_n;
			seq_q <= seq_n;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_RUN;
						op_q      <= operation;
						enc_err_q <= too_large;
						enc_k_q   <= enc_k_new;
						idx_q     <= '0;
					end
				end
				ST_RUN: begin
					if (done)
						state_q <= ST_IDLE;
					if (ctl.enc_step)
						idx_q <= idx_q + LEN_W'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
			if (res_valid)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_q <= operation ? byte_in : value[BYTE_W-1:0];
		if (res_valid) begin
			kind_q       <= res_kind;
			byte_out_q   <= res_byte;
			value_out_q  <= res_value;
			byte_count_q <= res_count;
			error_code_q <= res_err;
			error_pos_q  <= res_pos;
			last_q       <= done;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign byte_out       = byte_out_q;
	assign value_out      = value_out_q;
	assign byte_count     = byte_count_q;
	assign error_code     = error_code_q;
	assign error_position = error_pos_q;
	assign last           = last_q;

	`ASSERT_IMPLIES(a_seq_covers_rem, clk, arst_n, rem_q != '0, seq_q > rem_q)
	`ASSERT_IMPLIES(a_error_is_last, clk, arst_n, out_valid_q && kind_q == KIND_ERROR, last_q)
	`ASSERT_IMPLIES(a_emit_index, clk, arst_n, state_q == ST_RUN && !op_q && idx_q != '0,
		enc_k_q >= LEN_W'(2) && idx_q < enc_k_q)

endmodule

`default_nettype wire

### rtl/ucodec_dp.sv
// ----------------------------------------------------------------------------
// ucodec_dp
// Codec datapath: encode work word, decode accumulator and the one
// shift-and-insert unit that both of them step through.
// ----------------------------------------------------------------------------
`default_nettype none

module ucodec_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ucodec_pkg::ucodec_ctl_t         ctl,
	input  wire logic [ucodec_pkg::VAL_W-1:0]    value_in,
	input  wire logic [ucodec_pkg::LEN_W-1:0]    enc_k,
	input  wire logic [ucodec_pkg::BYTE_W-1:0]   byte_in,
	output logic      [ucodec_pkg::CHUNK_W-1:0]  chunk,
	output logic      [ucodec_pkg::VAL_W-1:0]    acc_next
);
	import ucodec_pkg::*;

	logic [WORK_W-1:0]  work_q;
	logic [VAL_W-1:0]   acc_q;
	logic [WORK_W-1:0]  sh_src;
	logic [CHUNK_W-1:0] sh_ins;
	logic [WORK_W-1:0]  sh_res;
	logic [BYTE_W-1:0]  hdr_payload;

	// shared unit: shift one chunk up and insert six new bits
	always_comb begin
		sh_src = ctl.dec_step ? WORK_W'(acc_q) : work_q;
		sh_ins = ctl.dec_step ? byte_in[CHUNK_W-1:0] : '0;
		sh_res = {sh_src[WORK_W-CHUNK_W-1:0], sh_ins};
	end

	assign acc_next    = sh_res[VAL_W-1:0];
	assign chunk       = work_q[WORK_W-1 -: CHUNK_W];
	assign hdr_payload = byte_in & (8'hFF >> lead_ones(byte_in));

	always_ff @(posedge clk) begin
		if (ctl.enc_load)
			work_q <= align(value_in, enc_k);
		else if (ctl.enc_step)
			work_q <= sh_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.dec_clear) begin
			acc_q <= '0;
		end else if (ctl.dec_load) begin
			acc_q <= VAL_W'(hdr_payload);
		end else if (ctl.dec_step) begin
			acc_q <= acc_next;
		end
	end

endmodule

`default_nettype wire
